FILE: rtl/mi_pkg.sv
// Package for the 64-bit modular inverse block.
// Holds word widths, sequencer states, adder operand codes and the control and
// status bundles shared by the controller and the datapath. No dependencies.
package mi_pkg;

  localparam int WordBits = 64;
  localparam int ModBits  = WordBits - 1;
  localparam int CntBits  = $clog2(WordBits);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUB,
    ST_FINISH,
    ST_FIXUP
  } state_e;

  // Operand selection for the coefficient adder
  typedef enum logic [1:0] {
    BOP_ACC,
    BOP_COEF,
    BOP_FIX
  } bop_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic align;
    logic sub;
    logic finish;
    logic fix_wr;
    bop_e bop;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic mod_zero;
    logic can_shift;
    logic cnt_zero;
    logic rem_zero;
  } stat_t;

endpackage

FILE: rtl/mi_in_if.sv
// Input channel of the modular inverse block: one word is a value and a modulus.
// Uses widths from mi_pkg.
interface mi_in_if;
  logic                       valid;
  logic                       ready;
  logic [mi_pkg::WordBits-1:0] value;
  logic [mi_pkg::ModBits-1:0]  modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

FILE: rtl/mi_out_if.sv
// Output channel of the modular inverse block: one word is the inverse.
// Uses widths from mi_pkg.
interface mi_out_if;
  logic                      valid;
  logic                      ready;
  logic [mi_pkg::ModBits-1:0] inverse;

  modport source (output valid, output inverse, input ready);
  modport sink   (input valid, input inverse, output ready);
endinterface

FILE: rtl/mi_addsub.sv
// Word-wide adder/subtractor with carry out, used for both datapath arithmetic units.
// Uses widths from mi_pkg.
module mi_addsub (
  input  logic [mi_pkg::WordBits-1:0] a_i,
  input  logic [mi_pkg::WordBits-1:0] b_i,
  input  logic                        sub_i,
  output logic [mi_pkg::WordBits-1:0] sum_o,
  output logic                        carry_o
);

  logic [mi_pkg::WordBits-1:0] b_inv;

  // Invert b and inject a carry for subtraction; carry out means a >= b
  assign b_inv = sub_i ? ~b_i : b_i;
  assign {carry_o, sum_o} = {1'b0, a_i} + {1'b0, b_inv} + {{mi_pkg::WordBits{1'b0}}, sub_i};

endmodule

FILE: rtl/mi_datapath.sv
// Datapath of the modular inverse block: remainders, Bezout coefficients,
// the shift-subtract divider registers and the result register.
// Depends on mi_pkg and mi_addsub.
module mi_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mi_pkg::ctrl_t               ctrl_i,
  output mi_pkg::stat_t               stat_o,
  input  logic [mi_pkg::WordBits-1:0] value_i,
  input  logic [mi_pkg::ModBits-1:0]  modulus_i,
  output logic [mi_pkg::ModBits-1:0]  inverse_o
);

  localparam int W = mi_pkg::WordBits;
  localparam int M = mi_pkg::ModBits;
  localparam int C = mi_pkg::CntBits;

  logic [W-1:0] rc_q, cp_q, cc_q;
  logic [W-1:0] d_q, rem_q, p_q;
  logic [C-1:0] cnt_q;
  logic [M-1:0] mod_q, inv_q;

  logic [W-1:0] a_b, a_sum, b_a, b_b, b_sum, p_sh;
  logic         a_carry, b_carry, b_sub;

  // Compare/subtract unit: trial shift in align, restoring step in sub
  assign a_b = ctrl_i.align ? {d_q[W-2:0], 1'b0} : d_q;

  mi_addsub u_cmp (
    .a_i     (rem_q),
    .b_i     (a_b),
    .sub_i   (1'b1),
    .sum_o   (a_sum),
    .carry_o (a_carry)
  );

  // Coefficient adder: quotient-times-coefficient accumulate, update, fixup
  assign p_sh = {p_q[W-2:0], 1'b0};

  always_comb begin
    b_a   = p_sh;
    b_b   = cc_q;
    b_sub = 1'b0;
    unique case (ctrl_i.bop)
      mi_pkg::BOP_ACC: begin
        b_a   = p_sh;
        b_b   = cc_q;
        b_sub = 1'b0;
      end
      mi_pkg::BOP_COEF: begin
        b_a   = cp_q;
        b_b   = p_q;
        b_sub = 1'b1;
      end
      mi_pkg::BOP_FIX: begin
        b_a   = cp_q;
        b_b   = {1'b0, mod_q};
        b_sub = 1'b0;
      end
      default: begin
        b_a   = p_sh;
        b_b   = cc_q;
        b_sub = 1'b0;
      end
    endcase
  end

  mi_addsub u_coef (
    .a_i     (b_a),
    .b_i     (b_b),
    .sub_i   (b_sub),
    .sum_o   (b_sum),
    .carry_o (b_carry)
  );

  // Status back to the sequencer
  assign stat_o.mod_zero  = (modulus_i == '0);
  assign stat_o.can_shift = ~d_q[W-1] & a_carry;
  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.rem_zero  = (rem_q == '0);

  // Advance the Euclid and divider registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rc_q  <= {1'b0, modulus_i};
      cp_q  <= {{(W-1){1'b0}}, 1'b1};
      cc_q  <= '0;
      mod_q <= modulus_i;
      d_q   <= {1'b0, modulus_i};
      rem_q <= value_i;
      p_q   <= '0;
      cnt_q <= '0;
    end else if (ctrl_i.align) begin
      if (stat_o.can_shift) begin
        d_q   <= {d_q[W-2:0], 1'b0};
        cnt_q <= cnt_q + C'(1);
      end
    end else if (ctrl_i.sub) begin
      if (a_carry) begin
        rem_q <= a_sum;
        p_q   <= b_sum;
      end else begin
        p_q   <= p_sh;
      end
      if (!stat_o.cnt_zero) begin
        d_q   <= {1'b0, d_q[W-1:1]};
        cnt_q <= cnt_q - C'(1);
      end
    end else if (ctrl_i.finish) begin
      rc_q  <= rem_q;
      cp_q  <= cc_q;
      cc_q  <= b_sum;
      d_q   <= rem_q;
      rem_q <= rc_q;
      p_q   <= '0;
      cnt_q <= '0;
    end
  end

  // Hold the reduced coefficient for the output
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fix_wr) begin
      inv_q <= cp_q[W-1] ? b_sum[M-1:0] : cp_q[M-1:0];
    end
  end

  assign inverse_o = inv_q;

  // Divisor is never zero while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.align || ctrl_i.sub) |-> (d_q != '0))
    else $error("divisor is zero during division");

  // Remainder ends below the divisor of the step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.finish |-> (rem_q < rc_q))
    else $error("remainder not below divisor");

  // Alignment never shifts past the top bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.align && stat_o.can_shift) |-> (cnt_q != {C{1'b1}}))
    else $error("alignment counter overflow");

endmodule

FILE: rtl/mi_ctrl.sv
// Sequencer of the modular inverse block: handshakes and step control.
// Depends on mi_pkg.
module mi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  mi_pkg::stat_t stat_i,
  output mi_pkg::ctrl_t ctrl_o
);

  mi_pkg::state_e state_q, state_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mi_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = stat_i.mod_zero ? mi_pkg::ST_FIXUP : mi_pkg::ST_ALIGN;
      end
      mi_pkg::ST_ALIGN: begin
        if (!stat_i.can_shift) state_d = mi_pkg::ST_SUB;
      end
      mi_pkg::ST_SUB: begin
        if (stat_i.cnt_zero) state_d = mi_pkg::ST_FINISH;
      end
      mi_pkg::ST_FINISH: begin
        state_d = stat_i.rem_zero ? mi_pkg::ST_FIXUP : mi_pkg::ST_ALIGN;
      end
      mi_pkg::ST_FIXUP: begin
        if (out_free) state_d = mi_pkg::ST_IDLE;
      end
      default: state_d = mi_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward the datapath and the channels
  always_comb begin
    ctrl_o        = '0;
    ctrl_o.bop    = mi_pkg::BOP_ACC;
    in_ready_o    = 1'b0;
    unique case (state_q)
      mi_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      mi_pkg::ST_ALIGN: ctrl_o.align = 1'b1;
      mi_pkg::ST_SUB: ctrl_o.sub = 1'b1;
      mi_pkg::ST_FINISH: begin
        ctrl_o.finish = 1'b1;
        ctrl_o.bop    = mi_pkg::BOP_COEF;
      end
      mi_pkg::ST_FIXUP: begin
        ctrl_o.fix_wr = out_free;
        ctrl_o.bop    = mi_pkg::BOP_FIX;
      end
      default: ctrl_o = '0;
    endcase
  end

  // Output word valid: set on result write, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.fix_wr) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mi_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted word leaves the sequencer busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while busy");

  // Last quotient bit leads to the coefficient update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mi_pkg::ST_SUB && stat_i.cnt_zero) |=> (state_q == mi_pkg::ST_FINISH))
    else $error("division did not finish");

  // A result write always shows up as a valid output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.fix_wr |=> out_valid_o)
    else $error("result written but not presented");

endmodule

FILE: rtl/modular_inverse_64.sv
// Modular inverse of a 64-bit value modulo a 63-bit modulus by the extended
// Euclidean algorithm, tracking the first Bezout coefficient only; a negative
// coefficient is brought into range by adding the modulus, a zero modulus gives 1,
// and non-coprime inputs give whatever coefficient the iteration ends with.
// One word is processed at a time and input ready is low while it runs. In each
// Euclid step one shared subtractor first aligns the divisor one bit per cycle,
// shifting it left by k bits, where k is the bit length of that step's quotient
// minus one (zero when the quotient is zero), and then produces one quotient bit
// per cycle; a whole word takes up to about 92 such steps. The result sits in an
// output register, so a new word can be taken while it waits.
// Depends on mi_pkg, mi_in_if, mi_out_if, mi_ctrl and mi_datapath.
module modular_inverse_64 (
  input  logic     clk_i,
  input  logic     rst_ni,
  mi_in_if.sink    in_if,
  mi_out_if.source out_if
);

  mi_pkg::ctrl_t ctrl;
  mi_pkg::stat_t stat;

  mi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  mi_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .value_i   (in_if.value),
    .modulus_i (in_if.modulus),
    .inverse_o (out_if.inverse)
  );

endmodule
